>>> hw/rtl/mdz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_pkg
// Shared types, register indexes and helper functions for the diagonal
// zigzag reorder block.
// ----------------------------------------------------------------------------
package mdz_pkg;

    localparam int SIZE_W = 4;
    localparam int CFG_W  = 4;
    localparam int IDX_W  = 1;
    localparam int PROD_W = 2 * SIZE_W;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    localparam t_cfg_idx REG_NUM_ROWS = 1'b0;
    localparam t_cfg_idx REG_NUM_COLS = 1'b1;

    localparam t_size SIZE_RESET = 4'd8;

    typedef struct packed {
        t_size rows;
        t_size cols;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic t_size clamp_size(input t_size v, input t_size maxv);
        t_size res;
        if (v == '0) begin
            res = t_size'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic t_size diag_lo(input t_size k, input t_size cols);
        t_size res;
        if (k >= cols) begin
            res = k - cols + t_size'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic t_size diag_hi(input t_size k, input t_size rows);
        t_size res;
        if (k < rows) begin
            res = k;
        end else begin
            res = rows - t_size'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mdz_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_front
// Holds the size registers, counts incoming words, produces the store write
// and posts a job when the word that completes the matrix arrives.
// ----------------------------------------------------------------------------
module mdz_front #(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire mdz_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [mdz_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [ELEM_WIDTH-1:0]          i_element,
    output logic                                o_wr_en,
    output logic [((MAX_ROWS*MAX_COLS) > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] o_wr_addr,
    output logic [ELEM_WIDTH-1:0]               o_wr_data,
    output logic                                o_push,
    output mdz_pkg::t_job                       o_job
);
    import mdz_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    t_size           r_rows;
    t_size           r_cols;
    logic [CW-1:0]   r_cnt;
    t_size           rows_eff;
    t_size           cols_eff;
    logic [PROD_W-1:0] total;
    logic [PROD_W-1:0] cnt_inc;
    logic            done;

    always_comb begin
        rows_eff = clamp_size(r_rows, t_size'(MAX_ROWS));
        cols_eff = clamp_size(r_cols, t_size'(MAX_COLS));
        total    = PROD_W'(rows_eff) * PROD_W'(cols_eff);
        cnt_inc  = PROD_W'(r_cnt) + PROD_W'(1);
        done     = i_accept && (cnt_inc >= total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_RESET;
            r_cols <= SIZE_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_ROWS: r_rows <= t_size'(i_cfg_data);
                    REG_NUM_COLS: r_cols <= t_size'(i_cfg_data);
                    default: ;
                endcase
            end
            if (done) begin
                r_cnt <= '0;
            end else if (i_accept) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    assign o_wr_en   = i_accept;
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_element;
    assign o_push    = done;
    assign o_job     = '{rows: rows_eff, cols: cols_eff};

endmodule
`default_nettype wire

>>> hw/rtl/mdz_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_queue
// Two-entry job queue between the load side and the scan side.
// ----------------------------------------------------------------------------
module mdz_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mdz_pkg::t_job i_job,
    input  wire logic          i_pop,
    output mdz_pkg::t_job      o_job,
    output mdz_pkg::t_q_stat   o_stat
);
    import mdz_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_job        = r_slot[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule
`default_nettype wire

>>> hw/rtl/mdz_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdz_back
// Holds the matrix store and walks it one anti-diagonal at a time, even
// diagonals from the bottom row up and odd diagonals from the top row down.
// ----------------------------------------------------------------------------
module mdz_back #(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [((MAX_ROWS*MAX_COLS) > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] i_wr_addr,
    input  wire logic [ELEM_WIDTH-1:0]   i_wr_data,
    input  wire mdz_pkg::t_job           i_job,
    input  wire mdz_pkg::t_q_stat        i_q_stat,
    output logic                         o_pop,
    output logic                         o_active,
    output logic                         o_strobe,
    output logic [ELEM_WIDTH-1:0]        o_element,
    output logic                         o_last
);
    import mdz_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    t_job                 r_job;
    t_size                r_k;
    t_size                r_i;
    logic                 r_vld;
    logic                 r_last;
    logic [ELEM_WIDTH-1:0] r_rdata;
    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    logic                 odd;
    t_size                k_max;
    t_size                lo;
    t_size                hi;
    t_size                k_nxt;
    logic                 diag_end;
    logic                 at_last;
    t_size                col;
    logic [PROD_W-1:0]    addr;

    always_comb begin
        odd      = r_k[0];
        k_max    = r_job.rows + r_job.cols - t_size'(2);
        lo       = diag_lo(r_k, r_job.cols);
        hi       = diag_hi(r_k, r_job.rows);
        k_nxt    = r_k + t_size'(1);
        diag_end = odd ? (r_i == hi) : (r_i == lo);
        at_last  = (r_k == k_max);
        col      = r_k - r_i;
        addr     = PROD_W'(r_i) * PROD_W'(r_job.cols) + PROD_W'(col);
        o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= mem[addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_vld  <= 1'b1;
                    r_last <= at_last;
                    if (diag_end) begin
                        if (at_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= k_nxt;
                            r_i <= odd ? diag_hi(k_nxt, r_job.rows)
                                       : diag_lo(k_nxt, r_job.cols);
                        end
                    end else begin
                        r_i <= odd ? r_i + t_size'(1) : r_i - t_size'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_active  = (r_state == S_SCAN);
    assign o_strobe  = r_vld;
    assign o_element = r_rdata;
    assign o_last    = r_last;

endmodule
`default_nettype wire

>>> hw/rtl/matrix_diagonal_zigzag_reorder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_reorder
// Loads a matrix word by word in row-major order and replays it in diagonal
// zigzag order.
// ----------------------------------------------------------------------------
// A word is taken on each cycle with start high and busy low, so loading runs
// at one word per cycle. The word that completes a rows x cols matrix raises
// busy, and the matrix is then read back from the store at one
// word per cycle, each on o_strobe for one cycle, the final one with
// o_last_out set. Busy stays high until the final word is read from the store,
// and the first result passes through the job queue, the scan state and the
// registered store read. Loading and replay share the store, so no word is
// taken while a matrix is replayed. The receiver cannot stall the results.
module matrix_diagonal_zigzag_reorder #(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire mdz_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [mdz_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_element_in,
    output logic                               o_strobe,
    output logic signed [ELEM_WIDTH-1:0]       o_element_out,
    output logic                               o_last_out
);
    import mdz_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic                  push;
    logic                  pop;
    logic                  active;
    t_job                  job_in;
    t_job                  job_out;
    t_q_stat               q_stat;
    logic [ELEM_WIDTH-1:0] element;

    assign busy   = !q_stat.empty || active;
    assign accept = start && !busy;

    mdz_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_element  (i_element_in),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_job      (job_in)
    );

    mdz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    mdz_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_job     (job_out),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_active  (active),
        .o_strobe  (o_strobe),
        .o_element (element),
        .o_last    (o_last_out)
    );

    assign o_element_out = $signed(element);

    a_strobe_follows_busy : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)
    ) else $error("result word without a matrix in replay");

    a_last_ends_burst : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_out) |=> !o_strobe
    ) else $error("result word directly after the final word of a matrix");

    a_no_queue_overflow : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full
    ) else $error("job posted to a full queue");

    a_no_load_in_replay : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        active |-> !wr_en
    ) else $error("store written while a matrix is replayed");

endmodule
`default_nettype wire

>>> tb/matrix_diagonal_zigzag_reorder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_reorder_tb
// Loads matrices word by word and checks the diagonal zigzag replay against a
// shadow copy of the matrix store. Directed tests cover the size limits, a
// one by one matrix, a small odd and even walk and a resize in mid-load.
// Random phases follow, with and without gaps on the sender.
// ----------------------------------------------------------------------------
module matrix_diagonal_zigzag_reorder_tb;

    import mdz_pkg::*;

    localparam int ELEM_W         = 16;
    localparam int STORE_WORDS    = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem;
        logic                     last;
    } t_scan_word;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    t_cfg_idx                 i_cfg_idx    = REG_NUM_ROWS;
    logic [CFG_W-1:0]         i_cfg_data   = '0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic signed [ELEM_W-1:0] i_element_in = '0;
    logic                     o_strobe;
    logic signed [ELEM_W-1:0] o_element_out;
    logic                     o_last_out;

    logic signed [ELEM_W-1:0] shadow_store [STORE_WORDS];
    int unsigned              shadow_count = 0;
    t_size                    shadow_rows  = SIZE_RESET;
    t_size                    shadow_cols  = SIZE_RESET;
    t_scan_word               scan_queue [$];
    int                       mismatches   = 0;
    int                       idle_cycles  = 0;
    int                       idle_pct     = 0;

    matrix_diagonal_zigzag_reorder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_element_in  (i_element_in),
        .o_strobe      (o_strobe),
        .o_element_out (o_element_out),
        .o_last_out    (o_last_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic int eff_size(input t_size v);
        if (v == '0) begin
            return 1;
        end
        if (v > t_size'(8)) begin
            return 8;
        end
        return int'(v);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_word();
        case ($urandom_range(9))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7fff;
            end
            2: begin
                return $urandom_range(1) ? 16'h0000 : 16'hffff;
            end
            default: begin
                return ELEM_W'($urandom);
            end
        endcase
    endfunction

    function automatic t_size rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            return t_size'($urandom_range(15));
        end else if (r < 22) begin
            return t_size'(8);
        end
        return t_size'($urandom_range(1, 4));
    endfunction

    task automatic load_and_scan(input logic signed [ELEM_W-1:0] w);
        int         rows;
        int         cols;
        int         i;
        int         j;
        int         n;
        t_scan_word item;
        rows = eff_size(shadow_rows);
        cols = eff_size(shadow_cols);
        if (shadow_count < STORE_WORDS) begin
            shadow_store[shadow_count] = w;
        end
        shadow_count = (shadow_count + 1) % 128;
        if (shadow_count >= rows * cols) begin
            n = 0;
            for (int k = 0; k < rows + cols - 1; k++) begin
                for (int s = 0; s < rows; s++) begin
                    i = (k % 2 == 1) ? s : rows - 1 - s;
                    if (i > k) begin
                        continue;
                    end
                    j = k - i;
                    if (j >= cols) begin
                        continue;
                    end
                    item.elem = shadow_store[i * cols + j];
                    item.last = (n == rows * cols - 1);
                    scan_queue.insert(scan_queue.size(), item);
                    n++;
                end
            end
            shadow_count = 0;
        end
    endtask

    // The caller is at a rising edge; start is left high after the word is taken.
    task automatic send_word(input logic [ELEM_W-1:0] w);
        start        <= 1'b1;
        i_element_in <= w;
        do begin
            @(posedge i_clk);
        end while (busy);
        load_and_scan(w);
    endtask

    task automatic idle_gap();
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start        <= 1'b0;
            i_element_in <= ELEM_W'($urandom);
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (scan_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sizes(input t_size rows, input t_size cols);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NUM_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        shadow_rows = rows;
        i_cfg_idx  <= REG_NUM_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        shadow_cols = cols;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic test_size_limits();
        logic [ELEM_W-1:0] pattern [8];
        pattern = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff,
                    16'h0001, 16'hfffe, 16'h5555, 16'haaaa};
        write_sizes(t_size'(0), t_size'(15));
        foreach (pattern[p]) begin
            send_word(pattern[p]);
        end
        write_sizes(t_size'(12), t_size'(0));
        foreach (pattern[p]) begin
            send_word(~pattern[p]);
        end
    endtask

    task automatic test_single_element();
        write_sizes(t_size'(1), t_size'(1));
        send_word(16'h8001);
    endtask

    task automatic test_small_walk();
        write_sizes(t_size'(2), t_size'(3));
        for (int p = 0; p < 6; p++) begin
            send_word(ELEM_W'(16'h1000 * (p + 1) + p));
        end
    endtask

    task automatic test_resize_mid_load();
        write_sizes(t_size'(3), t_size'(3));
        for (int p = 0; p < 4; p++) begin
            send_word(rand_word());
        end
        write_sizes(t_size'(2), t_size'(2));
        send_word(rand_word());
    endtask

    task automatic test_random(input int pct, input int budget);
        int  sent;
        int  need;
        int  n;
        int  total;
        bit  resize_pending;
        sent           = 0;
        resize_pending = 0;
        idle_pct       = pct;
        while (sent < budget || shadow_count != 0) begin
            if (shadow_count == 0 || resize_pending) begin
                write_sizes(rand_size(), rand_size());
            end
            total = eff_size(shadow_rows) * eff_size(shadow_cols);
            need  = (shadow_count >= total) ? 1 : total - int'(shadow_count);
            n     = need;
            resize_pending = 0;
            if (need > 1 && $urandom_range(99) < 20) begin
                n              = $urandom_range(1, need - 1);
                resize_pending = 1;
            end
            for (int p = 0; p < n; p++) begin
                idle_gap();
                send_word(rand_word());
                sent++;
            end
        end
        idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_scan_word want;
        if (i_rst_n && o_strobe) begin
            if (scan_queue.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("unexpected word: element %0d last %0b",
                             o_element_out, o_last_out);
                end
                mismatches++;
            end else begin
                want = scan_queue.pop_front();
                if (o_element_out !== want.elem || o_last_out !== want.last) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("word mismatch: expected %0d last %0b, got %0d last %0b",
                                 want.elem, want.last, o_element_out, o_last_out);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("matrix_diagonal_zigzag_reorder test failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_size_limits();
        test_single_element();
        test_small_walk();
        test_resize_mid_load();
        test_random(0, 70);
        test_random(82, 70);
        test_random(0, 70);
        test_random(17, 70);
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && scan_queue.size() == 0) begin
            $display("matrix_diagonal_zigzag_reorder test passed");
        end else begin
            $display("matrix_diagonal_zigzag_reorder test failed");
        end
        $finish;
    end

endmodule

>>> matrix_diagonal_zigzag_reorder.f
hw/rtl/mdz_pkg.sv
hw/rtl/mdz_front.sv
hw/rtl/mdz_queue.sv
hw/rtl/mdz_back.sv
hw/rtl/matrix_diagonal_zigzag_reorder.sv
tb/matrix_diagonal_zigzag_reorder_tb.sv
